// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 32;
	localparam int FIELD_BITS   = 32;
	localparam int COUNT_BITS   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_INS_FULL  = 2'd2
	} status_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic upd;            // apply the beat this cycle
		logic pop;            // 1 shift toward the head, 0 insert
		logic largest_first;  // current serving order
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// spq_cmd_if
// Request channel: operation, key and payload with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] key;
	logic [31:0] payload;

	modport source (output valid, output op, output key, output payload, input ready);
	modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: popped entry, status, head and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if #(
	parameter int CNT_W = spq_pkg::COUNT_BITS
);
	logic             valid;
	logic             ready;
	logic [31:0]      popped_key;
	logic [31:0]      popped_payload;
	logic             popped_valid;
	logic [1:0]       status;
	logic [31:0]      head_key;
	logic [31:0]      head_payload;
	logic             head_valid;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output popped_key, output popped_payload,
		output popped_valid, output status, output head_key, output head_payload,
		output head_valid, output entry_count, input ready);
	modport sink (input valid, input popped_key, input popped_payload,
		input popped_valid, input status, input head_key, input head_payload,
		input head_valid, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : request beats. op insert places key/payload ahead of every entry
//          not served strictly before it (newest first among equal keys);
//          op pop removes the head entry.
//   rsp  : one response beat per request: popped entry, status, head after
//          the request and entry count.
//   cfg  : cfg_we/cfg_wdata write the largest_first order bit; write only
//          while no request is in flight.
// Timing: a request is applied to all cells in the cycle it is accepted and
//   its response is registered; a new request can be taken every cycle
//   unless a response is stalled. The cycle length is set by the one-bit
//   position chain that ripples through the compare of every cell.
// Reset: entry count clears to zero, order resets to largest first; the
//   cell contents are left as they are and are never shown while empty.
// Stall: while a response waits and rsp.ready is low, cmd.ready drops and
//   the queue holds its contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH    = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	spq_cmd_if.sink    cmd,
	spq_rsp_if.source  rsp,
	input  wire        cfg_we,
	input  wire        cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int FB    = spq_pkg::FIELD_BITS;

	// order register and fill count
	logic             largest_first_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// output register
	logic             rsp_valid_q;
	logic [FB-1:0]    popped_key_q;
	logic [FB-1:0]    popped_payload_q;
	logic             popped_valid_q;
	spq_pkg::status_t status_q;
	logic [FB-1:0]    head_key_q;
	logic [FB-1:0]    head_payload_q;
	logic             head_valid_q;
	logic [CNT_W-1:0] entry_count_q;

	logic             accept;
	logic             is_pop;
	logic             full;
	logic             empty;
	spq_pkg::cell_cmd_t cell_cmd;
	spq_pkg::status_t status_d;
	logic [KEY_BITS-1:0] new_key;

	// cell chain
	logic [KEY_BITS-1:0] key_q_a     [DEPTH];
	logic [31:0]         payload_q_a [DEPTH];
	logic [KEY_BITS-1:0] key_d_a     [DEPTH];
	logic [31:0]         payload_d_a [DEPTH];
	logic                found       [DEPTH+1];

	// take a new request whenever the output register is free or draining
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_pop    = (cmd.op == spq_pkg::OP_POP);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign new_key   = KEY_BITS'(cmd.key);

	// drop inserts into a full queue and pops of an empty one
	assign cell_cmd.upd           = accept && (is_pop ? !empty : !full);
	assign cell_cmd.pop           = is_pop;
	assign cell_cmd.largest_first = largest_first_q;

	always_comb begin
		count_d  = count_q;
		status_d = spq_pkg::ST_OK;
		if (is_pop) begin
			if (empty) status_d = spq_pkg::ST_POP_EMPTY;
			else       count_d  = count_q - CNT_W'(1);
		end else begin
			if (full) status_d = spq_pkg::ST_INS_FULL;
			else      count_d  = count_q + CNT_W'(1);
		end
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] prev_key;
		logic [31:0]         prev_payload;
		logic [KEY_BITS-1:0] next_key;
		logic [31:0]         next_payload;

		if (i == 0) begin : g_first
			assign prev_key     = '0;
			assign prev_payload = '0;
		end else begin : g_mid
			assign prev_key     = key_q_a[i-1];
			assign prev_payload = payload_q_a[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_key     = '0;
			assign next_payload = '0;
		end else begin : g_inner
			assign next_key     = key_q_a[i+1];
			assign next_payload = payload_q_a[i+1];
		end

		spq_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk          (clk),
			.cmd          (cell_cmd),
			.count        (count_q),
			.new_key      (new_key),
			.new_payload  (cmd.payload),
			.found_in     (found[i]),
			.found_out    (found[i+1]),
			.prev_key     (prev_key),
			.prev_payload (prev_payload),
			.next_key     (next_key),
			.next_payload (next_payload),
			.key_q        (key_q_a[i]),
			.payload_q    (payload_q_a[i]),
			.key_d        (key_d_a[i]),
			.payload_d    (payload_d_a[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_first_q <= 1'b1;
		end else if (cfg_we) begin
			largest_first_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// capture the response beat; the head comes from cell 0's next value
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_pop && !empty) begin
				popped_key_q     <= FB'(key_q_a[0]);
				popped_payload_q <= payload_q_a[0];
				popped_valid_q   <= 1'b1;
			end else begin
				popped_key_q     <= '0;
				popped_payload_q <= '0;
				popped_valid_q   <= 1'b0;
			end
			status_q      <= status_d;
			entry_count_q <= count_d;
			if (count_d != '0) begin
				head_key_q     <= FB'(key_d_a[0]);
				head_payload_q <= payload_d_a[0];
				head_valid_q   <= 1'b1;
			end else begin
				head_key_q     <= '0;
				head_payload_q <= '0;
				head_valid_q   <= 1'b0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_key     = popped_key_q;
	assign rsp.popped_payload = popped_payload_q;
	assign rsp.popped_valid   = popped_valid_q;
	assign rsp.status         = status_q;
	assign rsp.head_key       = head_key_q;
	assign rsp.head_payload   = head_payload_q;
	assign rsp.head_valid     = head_valid_q;
	assign rsp.entry_count    = entry_count_q;

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds an entry, decides whether a new
// entry lands here, and takes a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
	parameter int CNT_W    = spq_pkg::COUNT_BITS,
	parameter int IDX      = 0
) (
	input  wire                     clk,
	input  wire spq_pkg::cell_cmd_t cmd,
	input  wire [CNT_W-1:0]         count,
	input  wire [KEY_BITS-1:0]      new_key,
	input  wire [31:0]              new_payload,
	input  wire                     found_in,
	output logic                    found_out,
	input  wire [KEY_BITS-1:0]      prev_key,
	input  wire [31:0]              prev_payload,
	input  wire [KEY_BITS-1:0]      next_key,
	input  wire [31:0]              next_payload,
	output logic [KEY_BITS-1:0]     key_q,
	output logic [31:0]             payload_q,
	output logic [KEY_BITS-1:0]     key_d,
	output logic [31:0]             payload_d
);

	logic occ;
	logic ahead;
	logic stop;

	// an occupied slot served strictly ahead of the new key lets it pass on
	assign occ       = count > CNT_W'(IDX);
	assign ahead     = cmd.largest_first ? (key_q > new_key) : (key_q < new_key);
	assign stop      = !(occ && ahead);
	assign found_out = found_in || stop;

	always_comb begin
		key_d     = key_q;
		payload_d = payload_q;
		if (cmd.upd) begin
			if (cmd.pop) begin
				key_d     = next_key;
				payload_d = next_payload;
			end else if (found_in) begin
				key_d     = prev_key;
				payload_d = prev_payload;
			end else if (stop) begin
				key_d     = new_key;
				payload_d = new_payload;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= key_d;
		payload_q <= payload_d;
	end

endmodule

`default_nettype wire
